/* rtl/cfas_pkg.sv */
`timescale 1ns / 1ps

package cfas_pkg;

    // fixed sizes
    localparam int SINE_TABLE_ENTRIES = 91;
    localparam int FRACTION_BITS      = 16;
    localparam int ANGLE_W            = 9;
    localparam int DEG_W              = 10;
    localparam int SIN_IDX_W          = 7;
    localparam int SIN_W              = 16;
    localparam int PROD_W             = 32;
    localparam int TRIP_W             = 48;
    localparam int MAT_W              = 46;
    localparam int CORNER_W           = 48;
    localparam int TERM_W             = 64;
    localparam int QUOT_W             = 33;
    localparam int REM_W              = 46;
    localparam int DIM_W              = 13;
    localparam int HALF_W             = 15;
    localparam int CENTRE_W           = 16;
    localparam int OUT_W              = 32;
    localparam int FACE_W             = 3;
    localparam int NUM_FACES          = 6;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    // register reset values
    localparam logic [HALF_W-1:0]   RST_HALF_SIZE = 15'd1600;
    localparam logic [DIM_W-1:0]    RST_IMAGE_DIM = 13'd100;

    // face codes
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd0;
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

    // quarter-wave sine, q1.14
    localparam logic [14:0] SINE_Q14 [0:SINE_TABLE_ENTRIES-1] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
        15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
        15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
        15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
        15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // one subtract brings any input below 720 down below 360
    function automatic logic [DEG_W-1:0] deg_reduce(input logic [DEG_W-1:0] a);
        deg_reduce = (a >= DEG_W'(360)) ? a - DEG_W'(360) : a;
    endfunction

    // sine of a reduced angle in q1.14
    function automatic logic signed [SIN_W-1:0] sin_deg(input logic [DEG_W-1:0] a);
        logic [DEG_W-1:0]     d;
        logic [SIN_IDX_W-1:0] idx;
        logic                 neg;
        logic [SIN_W-1:0]     mag;
        d = deg_reduce(a);
        if (d < DEG_W'(90)) begin
            idx = SIN_IDX_W'(d);
            neg = 1'b0;
        end else if (d < DEG_W'(180)) begin
            idx = SIN_IDX_W'(DEG_W'(180) - d);
            neg = 1'b0;
        end else if (d < DEG_W'(270)) begin
            idx = SIN_IDX_W'(d - DEG_W'(180));
            neg = 1'b1;
        end else begin
            idx = SIN_IDX_W'(DEG_W'(360) - d);
            neg = 1'b1;
        end
        mag = {1'b0, SINE_Q14[idx]};
        sin_deg = neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [SIN_W-1:0] cos_deg(input logic [DEG_W-1:0] a);
        cos_deg = sin_deg(deg_reduce(a) + DEG_W'(90));
    endfunction

    // rotation rows needed for the screen plane, plus face visibility
    typedef struct packed {
        logic signed [MAT_W-1:0] m00;
        logic signed [MAT_W-1:0] m01;
        logic signed [MAT_W-1:0] m02;
        logic signed [MAT_W-1:0] m10;
        logic signed [MAT_W-1:0] m11;
        logic signed [MAT_W-1:0] m12;
        logic [NUM_FACES-1:0]    vis;
    } item_t;

    // one visible face to be worked out
    typedef struct packed {
        logic [FACE_W-1:0]       face;
        logic                    last;
        logic signed [MAT_W-1:0] m00;
        logic signed [MAT_W-1:0] m01;
        logic signed [MAT_W-1:0] m02;
        logic signed [MAT_W-1:0] m10;
        logic signed [MAT_W-1:0] m11;
        logic signed [MAT_W-1:0] m12;
    } job_t;

    // divider operand and result
    typedef struct packed {
        logic [REM_W-1:0] t;
        logic             neg;
        logic             ovf;
    } div_in_t;

    typedef struct packed {
        logic [QUOT_W-1:0] q;
        logic              neg;
        logic              ovf;
    } div_out_t;

endpackage

/* rtl/cube_face_affine_setup.sv */
`timescale 1ns / 1ps

// cube face affine setup
// input channel (s_valid/s_ready) takes one item of three rotation angles in
// whole degrees per frame. for each face of the rotated cube that faces the
// viewer, in face order, the result channel (m_valid/m_ready) delivers one item
// with the affine blit terms in signed q16.16 and m_last_face on the final one;
// one to three result items per input item.
// pipeline: an item passes through 43 register stages (four matrix stages,
// two face issue stages, three term stages, a 33-stage divider and the output
// register).
// a new item can enter every cycle while s_ready is high, but each item holds the
// face issue stage until all of its visible faces are issued, one per cycle, so
// with three visible faces the input waits while results come out one per cycle.
// configuration: cfg_wr_en, cfg_index and cfg_data write a register at once;
// write only while no item is in flight.
// reset: aresetn low clears all valid bits and loads the register defaults.
// a stall on m_ready freezes the whole pipeline in place and drops s_ready;
// nothing is lost or repeated.
module cube_face_affine_setup #(
    parameter int FRACTION_BITS = cfas_pkg::FRACTION_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [cfas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cfas_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [cfas_pkg::ANGLE_W-1:0]          s_angle_x,
    input  logic [cfas_pkg::ANGLE_W-1:0]          s_angle_y,
    input  logic [cfas_pkg::ANGLE_W-1:0]          s_angle_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cfas_pkg::FACE_W-1:0]           m_face_index,
    output logic signed [cfas_pkg::OUT_W-1:0]     m_scale_x,
    output logic signed [cfas_pkg::OUT_W-1:0]     m_shear_x,
    output logic signed [cfas_pkg::OUT_W-1:0]     m_offset_x,
    output logic signed [cfas_pkg::OUT_W-1:0]     m_shear_y,
    output logic signed [cfas_pkg::OUT_W-1:0]     m_scale_y,
    output logic signed [cfas_pkg::OUT_W-1:0]     m_offset_y,
    output logic                                  m_last_face
);

    logic [cfas_pkg::HALF_W-1:0]          half_size_reg;
    logic signed [cfas_pkg::CENTRE_W-1:0] center_x_reg, center_y_reg;
    logic [cfas_pkg::DIM_W-1:0]           image_width_reg, image_height_reg;

    logic            en;
    logic            mat_en;
    logic            mat_valid;
    cfas_pkg::item_t mat_item;
    logic            job_valid;
    cfas_pkg::job_t  job;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_size_reg    <= cfas_pkg::RST_HALF_SIZE;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            image_width_reg  <= cfas_pkg::RST_IMAGE_DIM;
            image_height_reg <= cfas_pkg::RST_IMAGE_DIM;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cfas_pkg::REG_HALF_SIZE:    half_size_reg    <= cfg_data[cfas_pkg::HALF_W-1:0];
                cfas_pkg::REG_CENTER_X:     center_x_reg     <= $signed(cfg_data);
                cfas_pkg::REG_CENTER_Y:     center_y_reg     <= $signed(cfg_data);
                cfas_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[cfas_pkg::DIM_W-1:0];
                cfas_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[cfas_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves when the output register is empty or being taken; the matrix also waits for face issue
    assign en      = !m_valid || m_ready;
    assign s_ready = mat_en;

    cfas_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (mat_en),
        .in_valid  (s_valid),
        .angle_x   (s_angle_x),
        .angle_y   (s_angle_y),
        .angle_z   (s_angle_z),
        .out_valid (mat_valid),
        .out_item  (mat_item)
    );

    cfas_face_issue u_issue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mat_valid),
        .in_item   (mat_item),
        .in_ready  (mat_en),
        .job_valid (job_valid),
        .job       (job)
    );

    cfas_term_calc #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_terms (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .job_valid    (job_valid),
        .job          (job),
        .half_size    (half_size_reg),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .out_valid    (m_valid),
        .out_face     (m_face_index),
        .out_scale_x  (m_scale_x),
        .out_shear_x  (m_shear_x),
        .out_offset_x (m_offset_x),
        .out_shear_y  (m_shear_y),
        .out_scale_y  (m_scale_y),
        .out_offset_y (m_offset_y),
        .out_last     (m_last_face)
    );

    // a result only ever names a real face
    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_face_index <= cfas_pkg::FACE_BOTTOM))
        else $error("result with unknown face index");
    // input is refused while a result waits unaccepted
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken during output stall");
    // a refused result stays put
    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_last_face) && $stable(m_face_index)))
        else $error("stalled result changed");

endmodule

/* rtl/cfas_matrix.sv */
`timescale 1ns / 1ps

module cfas_matrix (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [cfas_pkg::ANGLE_W-1:0]    angle_x,
    input  logic [cfas_pkg::ANGLE_W-1:0]    angle_y,
    input  logic [cfas_pkg::ANGLE_W-1:0]    angle_z,
    output logic                            out_valid,
    output cfas_pkg::item_t                 out_item
);

    localparam int SW = cfas_pkg::SIN_W;
    localparam int PW = cfas_pkg::PROD_W;
    localparam int TW = cfas_pkg::TRIP_W;
    localparam int MW = cfas_pkg::MAT_W;
    localparam int DW = cfas_pkg::DEG_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [SW-1:0] sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    logic signed [PW-1:0] czcy_reg, czsy_reg, szcx_reg, szsy_reg, czcx_reg;
    logic signed [PW-1:0] szcy_reg, cysx_reg, cycx_reg, szsx_reg, czsx_reg;
    logic signed [SW-1:0] sx2_reg, cx2_reg, sy2_reg;
    logic signed [TW-1:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [PW-1:0] czcy3_reg, szcx3_reg, szsx3_reg, czcx3_reg, czsx3_reg;
    logic signed [PW-1:0] szcy3_reg, cysx3_reg, cycx3_reg;
    logic signed [SW-1:0] sy3_reg;
    cfas_pkg::item_t      item_reg;

    logic signed [MW-1:0] m20, m21, m22;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: table lookups
    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg <= cfas_pkg::sin_deg(DW'(angle_x));
            cx_reg <= cfas_pkg::cos_deg(DW'(angle_x));
            sy_reg <= cfas_pkg::sin_deg(DW'(angle_y));
            cy_reg <= cfas_pkg::cos_deg(DW'(angle_y));
            sz_reg <= cfas_pkg::sin_deg(DW'(angle_z));
            cz_reg <= cfas_pkg::cos_deg(DW'(angle_z));
        end
    end

    // stage 2: pair products
    always_ff @(posedge aclk) begin
        if (en) begin
            czcy_reg <= cz_reg * cy_reg;
            czsy_reg <= cz_reg * sy_reg;
            szcx_reg <= sz_reg * cx_reg;
            szsy_reg <= sz_reg * sy_reg;
            czcx_reg <= cz_reg * cx_reg;
            szcy_reg <= sz_reg * cy_reg;
            cysx_reg <= cy_reg * sx_reg;
            cycx_reg <= cy_reg * cx_reg;
            szsx_reg <= sz_reg * sx_reg;
            czsx_reg <= cz_reg * sx_reg;
            sx2_reg  <= sx_reg;
            cx2_reg  <= cx_reg;
            sy2_reg  <= sy_reg;
        end
    end

    // stage 3: triple products
    always_ff @(posedge aclk) begin
        if (en) begin
            t01_reg   <= czsy_reg * sx2_reg;
            t02_reg   <= czsy_reg * cx2_reg;
            t11_reg   <= szsy_reg * sx2_reg;
            t12_reg   <= szsy_reg * cx2_reg;
            czcy3_reg <= czcy_reg;
            szcx3_reg <= szcx_reg;
            szsx3_reg <= szsx_reg;
            czcx3_reg <= czcx_reg;
            czsx3_reg <= czsx_reg;
            szcy3_reg <= szcy_reg;
            cysx3_reg <= cysx_reg;
            cycx3_reg <= cycx_reg;
            sy3_reg   <= sy2_reg;
        end
    end

    // third row only decides visibility
    assign m20 = -(MW'(sy3_reg) <<< 28);
    assign m21 = MW'(cysx3_reg) <<< 14;
    assign m22 = MW'(cycx3_reg) <<< 14;

    // stage 4: matrix entries in signed q4.42
    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg.m00 <= MW'(czcy3_reg) <<< 14;
            item_reg.m01 <= MW'(t01_reg) - (MW'(szcx3_reg) <<< 14);
            item_reg.m02 <= MW'(t02_reg) + (MW'(szsx3_reg) <<< 14);
            item_reg.m10 <= MW'(szcy3_reg) <<< 14;
            item_reg.m11 <= MW'(t11_reg) + (MW'(czcx3_reg) <<< 14);
            item_reg.m12 <= MW'(t12_reg) - (MW'(czsx3_reg) <<< 14);
            item_reg.vis <= {m21 < 0, m21 > 0, m20 < 0, m20 > 0, m22 > 0, m22 < 0};
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/cfas_face_issue.sv */
`timescale 1ns / 1ps

module cfas_face_issue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cfas_pkg::item_t in_item,
    output logic            in_ready,
    output logic            job_valid,
    output cfas_pkg::job_t  job
);

    localparam int NF = cfas_pkg::NUM_FACES;

    logic [NF-1:0]                 pend_reg;
    cfas_pkg::item_t               item_reg;
    logic                          job_valid_reg;
    cfas_pkg::job_t                job_reg;
    logic [cfas_pkg::FACE_W-1:0]   low_face;
    logic [NF-1:0]                 pend_after;

    // lowest pending face goes first
    always_comb begin
        low_face = cfas_pkg::FACE_BACK;
        for (int f = NF - 1; f >= 0; f--) begin
            if (pend_reg[f]) begin
                low_face = cfas_pkg::FACE_W'(f);
            end
        end
    end

    assign pend_after = pend_reg & ~(NF'(1) << low_face);
    assign in_ready   = en && (pend_after == '0);

    // pending mask, reloaded once the last face has gone out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            job_valid_reg <= 1'b0;
        end else if (en) begin
            job_valid_reg <= (pend_reg != '0);
            if (pend_after == '0) begin
                pend_reg <= in_valid ? in_item.vis : '0;
            end else begin
                pend_reg <= pend_after;
            end
        end
    end

    // item hold and face job
    always_ff @(posedge aclk) begin
        if (en) begin
            if (pend_after == '0) begin
                item_reg <= in_item;
            end
            job_reg.face <= low_face;
            job_reg.last <= (pend_after == '0);
            job_reg.m00  <= item_reg.m00;
            job_reg.m01  <= item_reg.m01;
            job_reg.m02  <= item_reg.m02;
            job_reg.m10  <= item_reg.m10;
            job_reg.m11  <= item_reg.m11;
            job_reg.m12  <= item_reg.m12;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    // opposite faces are never both pending
    a_back_front: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_reg[0] && pend_reg[1]))
        else $error("back and front both pending");
    a_right_left: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_reg[2] && pend_reg[3]))
        else $error("right and left both pending");
    a_top_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_reg[4] && pend_reg[5]))
        else $error("top and bottom both pending");
    // a face not marked last leaves more faces to send
    a_more_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !job_reg.last) |-> (pend_reg != '0))
        else $error("face without last flag but nothing pending");

endmodule

/* rtl/cfas_divider.sv */
`timescale 1ns / 1ps

module cfas_divider (
    input  logic                          aclk,
    input  logic                          en,
    input  cfas_pkg::div_in_t             din,
    input  logic [cfas_pkg::DIM_W-1:0]    divisor,
    output cfas_pkg::div_out_t            dout
);

    localparam int QW = cfas_pkg::QUOT_W;
    localparam int RW = cfas_pkg::REM_W;

    logic [RW-1:0] rem_reg [QW-1];
    logic [QW-1:0] q_reg   [QW];
    logic          neg_reg [QW];
    logic          ovf_reg [QW];

    // one quotient bit per stage, top bit first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic          neg_in;
        logic          ovf_in;
        logic [RW-1:0] sub;
        logic          fits;

        if (k == 0) begin : g_first
            assign rem_in = din.t;
            assign q_in   = '0;
            assign neg_in = din.neg;
            assign ovf_in = din.ovf;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        assign sub  = RW'(divisor) << BIT;
        assign fits = (rem_in >= sub);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]   <= fits ? (q_in | (QW'(1) << BIT)) : q_in;
                neg_reg[k] <= neg_in;
                ovf_reg[k] <= ovf_in;
            end
        end

        if (k < QW - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= fits ? rem_in - sub : rem_in;
                end
            end
        end
    end

    assign dout.q   = q_reg[QW-1];
    assign dout.neg = neg_reg[QW-1];
    assign dout.ovf = ovf_reg[QW-1];

endmodule

/* rtl/cfas_term_calc.sv */
`timescale 1ns / 1ps

module cfas_term_calc #(
    parameter int FRACTION_BITS = cfas_pkg::FRACTION_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 job_valid,
    input  cfas_pkg::job_t                       job,
    input  logic [cfas_pkg::HALF_W-1:0]          half_size,
    input  logic signed [cfas_pkg::CENTRE_W-1:0] center_x,
    input  logic signed [cfas_pkg::CENTRE_W-1:0] center_y,
    input  logic [cfas_pkg::DIM_W-1:0]           image_width,
    input  logic [cfas_pkg::DIM_W-1:0]           image_height,
    output logic                                 out_valid,
    output logic [cfas_pkg::FACE_W-1:0]          out_face,
    output logic signed [cfas_pkg::OUT_W-1:0]    out_scale_x,
    output logic signed [cfas_pkg::OUT_W-1:0]    out_shear_x,
    output logic signed [cfas_pkg::OUT_W-1:0]    out_offset_x,
    output logic signed [cfas_pkg::OUT_W-1:0]    out_shear_y,
    output logic signed [cfas_pkg::OUT_W-1:0]    out_scale_y,
    output logic signed [cfas_pkg::OUT_W-1:0]    out_offset_y,
    output logic                                 out_last
);

    localparam int MW     = cfas_pkg::MAT_W;
    localparam int KW     = cfas_pkg::CORNER_W;
    localparam int TW     = cfas_pkg::TERM_W;
    localparam int OW     = cfas_pkg::OUT_W;
    localparam int QW     = cfas_pkg::QUOT_W;
    localparam int RW     = cfas_pkg::REM_W;
    localparam int DW     = cfas_pkg::DIM_W;
    localparam int FW     = cfas_pkg::FACE_W;
    localparam int USHIFT = 46 - FRACTION_BITS;
    localparam int CSHIFT = FRACTION_BITS - 4;
    localparam logic signed [TW-1:0] SAT_MAX = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] SAT_MIN = -TW'(64'sd2147483648);

    typedef struct packed {
        logic [FW-1:0]          face;
        logic                   last;
        logic signed [OW-1:0]   off_x;
        logic signed [OW-1:0]   off_y;
    } pay_t;

    logic [DW-1:0] wz, hz;

    // selection
    logic signed [MW-1:0] mx [3];
    logic signed [MW-1:0] my [3];
    logic [1:0]           w_col, h_col;
    logic                 w_neg, h_neg;
    logic [2:0]           a_sg;
    logic signed [KW-1:0] kx, ky;

    logic                 v0_reg, v1_reg, v2_reg;
    logic [FW-1:0]        face0_reg, face1_reg;
    logic                 last0_reg, last1_reg;
    logic signed [MW-1:0] xw_reg, xh_reg, yw_reg, yh_reg;
    logic signed [KW-1:0] kx_reg, ky_reg;
    logic signed [TW-1:0] pxw_reg, pxh_reg, pyw_reg, pyh_reg, pkx_reg, pky_reg;
    logic signed [cfas_pkg::SIN_W-1:0] s_signed;

    cfas_pkg::div_in_t    dxw_reg, dxh_reg, dyw_reg, dyh_reg;
    cfas_pkg::div_out_t   qxw, qxh, qyw, qyh;
    pay_t                 pay2_reg;
    pay_t                 pl_reg [QW];
    logic                 vl_reg [QW];

    logic                 out_valid_reg, out_last_reg;
    logic [FW-1:0]        out_face_reg;
    logic signed [OW-1:0] sx_out_reg, shx_out_reg, tx_out_reg;
    logic signed [OW-1:0] shy_out_reg, sy_out_reg, ty_out_reg;

    // a zero dimension counts as one
    assign wz = (image_width == '0) ? DW'(1) : image_width;
    assign hz = (image_height == '0) ? DW'(1) : image_height;

    // twice the scaled difference, plus half the divisor for rounding, shifted down to the divider operand
    function automatic cfas_pkg::div_in_t prep_div(input logic signed [TW-1:0] p,
                                                   input logic [DW-1:0] d);
        logic signed [TW-1:0] dbl;
        logic [TW-1:0]        mag;
        logic [TW-1:0]        t;
        cfas_pkg::div_in_t    r;
        dbl   = p <<< 1;
        mag   = dbl[TW-1] ? TW'(-dbl) : TW'(dbl);
        t     = (mag + (TW'(d) << (USHIFT - 1))) >> USHIFT;
        r.t   = t[RW-1:0];
        r.neg = dbl[TW-1];
        r.ovf = (t >= (TW'(d) << QW));
        return r;
    endfunction

    // corner coordinate rounded to the output fraction, plus centre, saturated
    function automatic logic signed [OW-1:0] offset_term(input logic signed [TW-1:0] p,
                                                        input logic signed [cfas_pkg::CENTRE_W-1:0] c);
        logic [TW-1:0]        mag;
        logic [TW-1:0]        q;
        logic signed [TW-1:0] v;
        mag = p[TW-1] ? TW'(-p) : TW'(p);
        q   = (mag + (TW'(1) << (USHIFT - 1))) >> USHIFT;
        v   = (p[TW-1] ? -$signed(q) : $signed(q)) + (TW'(c) <<< CSHIFT);
        if (v > SAT_MAX) begin
            v = SAT_MAX;
        end else if (v < SAT_MIN) begin
            v = SAT_MIN;
        end
        return v[OW-1:0];
    endfunction

    // signed and saturated quotient
    function automatic logic signed [OW-1:0] quot_term(input cfas_pkg::div_out_t r);
        logic signed [OW-1:0] v;
        if (r.ovf) begin
            v = r.neg ? SAT_MIN[OW-1:0] : SAT_MAX[OW-1:0];
        end else if (!r.neg) begin
            v = (r.q > QW'(SAT_MAX)) ? SAT_MAX[OW-1:0] : r.q[OW-1:0];
        end else begin
            v = (r.q > QW'(-SAT_MIN)) ? SAT_MIN[OW-1:0] : OW'(-r.q);
        end
        return v;
    endfunction

    assign mx[0] = job.m00;
    assign mx[1] = job.m01;
    assign mx[2] = job.m02;
    assign my[0] = job.m10;
    assign my[1] = job.m11;
    assign my[2] = job.m12;

    // per face: edge columns and the signs of its first corner
    always_comb begin
        case (job.face)
            cfas_pkg::FACE_BACK: begin
                w_col = 2'd1; w_neg = 1'b0; h_col = 2'd0; h_neg = 1'b0; a_sg = 3'b000;
            end
            cfas_pkg::FACE_FRONT: begin
                w_col = 2'd0; w_neg = 1'b0; h_col = 2'd1; h_neg = 1'b0; a_sg = 3'b100;
            end
            cfas_pkg::FACE_RIGHT: begin
                w_col = 2'd2; w_neg = 1'b1; h_col = 2'd1; h_neg = 1'b0; a_sg = 3'b101;
            end
            cfas_pkg::FACE_LEFT: begin
                w_col = 2'd2; w_neg = 1'b0; h_col = 2'd1; h_neg = 1'b0; a_sg = 3'b000;
            end
            cfas_pkg::FACE_TOP: begin
                w_col = 2'd0; w_neg = 1'b0; h_col = 2'd2; h_neg = 1'b1; a_sg = 3'b110;
            end
            cfas_pkg::FACE_BOTTOM: begin
                w_col = 2'd0; w_neg = 1'b0; h_col = 2'd2; h_neg = 1'b0; a_sg = 3'b000;
            end
            default: begin
                w_col = 2'd1; w_neg = 1'b0; h_col = 2'd0; h_neg = 1'b0; a_sg = 3'b000;
            end
        endcase
    end

    // first corner of the face, before scaling
    always_comb begin
        kx = '0;
        ky = '0;
        for (int j = 0; j < 3; j++) begin
            kx = a_sg[j] ? kx + KW'(mx[j]) : kx - KW'(mx[j]);
            ky = a_sg[j] ? ky + KW'(my[j]) : ky - KW'(my[j]);
        end
    end

    assign s_signed = $signed({1'b0, half_size});

    // valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= job_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // stage 0: select, stage 1: scale by half size, stage 2: round and saturate
    always_ff @(posedge aclk) begin
        if (en) begin
            face0_reg <= job.face;
            last0_reg <= job.last;
            xw_reg    <= w_neg ? -mx[w_col] : mx[w_col];
            xh_reg    <= h_neg ? -mx[h_col] : mx[h_col];
            yw_reg    <= w_neg ? -my[w_col] : my[w_col];
            yh_reg    <= h_neg ? -my[h_col] : my[h_col];
            kx_reg    <= kx;
            ky_reg    <= ky;

            face1_reg <= face0_reg;
            last1_reg <= last0_reg;
            pxw_reg   <= s_signed * xw_reg;
            pxh_reg   <= s_signed * xh_reg;
            pyw_reg   <= s_signed * yw_reg;
            pyh_reg   <= s_signed * yh_reg;
            pkx_reg   <= s_signed * kx_reg;
            pky_reg   <= s_signed * ky_reg;

            dxw_reg        <= prep_div(pxw_reg, wz);
            dxh_reg        <= prep_div(pxh_reg, hz);
            dyw_reg        <= prep_div(pyw_reg, wz);
            dyh_reg        <= prep_div(pyh_reg, hz);
            pay2_reg.face  <= face1_reg;
            pay2_reg.last  <= last1_reg;
            pay2_reg.off_x <= offset_term(pkx_reg, center_x);
            pay2_reg.off_y <= offset_term(pky_reg, center_y);
        end
    end

    // the four divisions
    cfas_divider u_div_xw (.aclk(aclk), .en(en), .din(dxw_reg), .divisor(wz), .dout(qxw));
    cfas_divider u_div_xh (.aclk(aclk), .en(en), .din(dxh_reg), .divisor(hz), .dout(qxh));
    cfas_divider u_div_yw (.aclk(aclk), .en(en), .din(dyw_reg), .divisor(wz), .dout(qyw));
    cfas_divider u_div_yh (.aclk(aclk), .en(en), .din(dyh_reg), .divisor(hz), .dout(qyh));

    // side payload alongside the divider stages
    for (genvar k = 0; k < QW; k++) begin : g_line
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vl_reg[k] <= 1'b0;
            end else if (en) begin
                vl_reg[k] <= (k == 0) ? v2_reg : vl_reg[(k == 0) ? 0 : k - 1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                pl_reg[k] <= (k == 0) ? pay2_reg : pl_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vl_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_face_reg <= pl_reg[QW-1].face;
            out_last_reg <= pl_reg[QW-1].last;
            tx_out_reg   <= pl_reg[QW-1].off_x;
            ty_out_reg   <= pl_reg[QW-1].off_y;
            sx_out_reg   <= quot_term(qxw);
            shx_out_reg  <= quot_term(qxh);
            shy_out_reg  <= quot_term(qyw);
            sy_out_reg   <= quot_term(qyh);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_face     = out_face_reg;
    assign out_last     = out_last_reg;
    assign out_scale_x  = sx_out_reg;
    assign out_shear_x  = shx_out_reg;
    assign out_offset_x = tx_out_reg;
    assign out_shear_y  = shy_out_reg;
    assign out_scale_y  = sy_out_reg;
    assign out_offset_y = ty_out_reg;

endmodule

/* dv/cube_face_affine_setup_tb.sv */
`timescale 1ns / 1ps

module cube_face_affine_setup_tb;

    typedef struct {
        logic [cfas_pkg::ANGLE_W-1:0] ax;
        logic [cfas_pkg::ANGLE_W-1:0] ay;
        logic [cfas_pkg::ANGLE_W-1:0] az;
    } angles_t;

    typedef struct {
        logic [cfas_pkg::FACE_W-1:0]       face;
        logic signed [cfas_pkg::OUT_W-1:0] sx;
        logic signed [cfas_pkg::OUT_W-1:0] shx;
        logic signed [cfas_pkg::OUT_W-1:0] tx;
        logic signed [cfas_pkg::OUT_W-1:0] shy;
        logic signed [cfas_pkg::OUT_W-1:0] sy;
        logic signed [cfas_pkg::OUT_W-1:0] ty;
        logic                              last;
    } face_terms_t;

    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;

    // corner sign bits: bit0 x, bit1 y, bit2 z
    localparam int CORNER_SIGN [0:7] = '{0, 1, 3, 2, 4, 5, 7, 6};
    // first corner, corner along width, corner along height
    localparam int FACE_CORNER [0:5][0:2] = '{
        '{0, 3, 1}, '{4, 5, 7}, '{5, 1, 6}, '{0, 4, 3}, '{7, 6, 3}, '{0, 1, 4}
    };

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [cfas_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [cfas_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                s_valid;
    logic                                s_ready;
    logic [cfas_pkg::ANGLE_W-1:0]        s_angle_x;
    logic [cfas_pkg::ANGLE_W-1:0]        s_angle_y;
    logic [cfas_pkg::ANGLE_W-1:0]        s_angle_z;
    logic                                m_valid;
    logic                                m_ready;
    logic [cfas_pkg::FACE_W-1:0]         m_face_index;
    logic signed [cfas_pkg::OUT_W-1:0]   m_scale_x;
    logic signed [cfas_pkg::OUT_W-1:0]   m_shear_x;
    logic signed [cfas_pkg::OUT_W-1:0]   m_offset_x;
    logic signed [cfas_pkg::OUT_W-1:0]   m_shear_y;
    logic signed [cfas_pkg::OUT_W-1:0]   m_scale_y;
    logic signed [cfas_pkg::OUT_W-1:0]   m_offset_y;
    logic                                m_last_face;

    cube_face_affine_setup dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_angle_x(s_angle_x), .s_angle_y(s_angle_y), .s_angle_z(s_angle_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_face_index(m_face_index), .m_scale_x(m_scale_x), .m_shear_x(m_shear_x),
        .m_offset_x(m_offset_x), .m_shear_y(m_shear_y), .m_scale_y(m_scale_y),
        .m_offset_y(m_offset_y), .m_last_face(m_last_face)
    );

    angles_t     frames_pending[$];
    face_terms_t face_terms_due[$];
    int          mismatches = 0;
    logic        no_idle = 1'b0;
    logic        hold_phase = 1'b0;

    // register copies
    longint      half_size = 1600;
    longint      centre_x = 0;
    longint      centre_y = 0;
    longint      img_w = 100;
    longint      img_h = 100;

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // sine of whole degrees, q1.14
    function automatic longint sine_of(int a);
        int d;
        d = a % 360;
        if (d < 90) return cfas_pkg::SINE_Q14[d];
        if (d < 180) return cfas_pkg::SINE_Q14[180 - d];
        if (d < 270) return -longint'(cfas_pkg::SINE_Q14[d - 180]);
        return -longint'(cfas_pkg::SINE_Q14[360 - d]);
    endfunction

    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [cfas_pkg::OUT_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[cfas_pkg::OUT_W-1:0];
    endfunction

    // expected face items for one frame
    task automatic predict_faces(angles_t a);
        longint sx, cx, sy, cy, sz, cz;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint px[8];
        longint py[8];
        longint kx, ky, w, h, unit, cscale;
        bit     vis[6];
        int     sg, total, n, c0, c1, c2;
        face_terms_t t;
        sx = sine_of(a.ax); cx = sine_of((a.ax % 360) + 90);
        sy = sine_of(a.ay); cy = sine_of((a.ay % 360) + 90);
        sz = sine_of(a.az); cz = sine_of((a.az % 360) + 90);
        m00 = cz * cy * 16384;
        m01 = cz * sy * sx - sz * cx * 16384;
        m02 = cz * sy * cx + sz * sx * 16384;
        m10 = sz * cy * 16384;
        m11 = sz * sy * sx + cz * cx * 16384;
        m12 = sz * sy * cx - cz * sx * 16384;
        m20 = -sy * 268435456;
        m21 = cy * sx * 16384;
        m22 = cy * cx * 16384;
        for (int c = 0; c < 8; c++) begin
            sg = CORNER_SIGN[c];
            kx = (sg[0] ? m00 : -m00) + (sg[1] ? m01 : -m01) + (sg[2] ? m02 : -m02);
            ky = (sg[0] ? m10 : -m10) + (sg[1] ? m11 : -m11) + (sg[2] ? m12 : -m12);
            px[c] = half_size * kx;
            py[c] = half_size * ky;
        end
        vis[0] = m22 < 0; vis[1] = m22 > 0;
        vis[2] = m20 > 0; vis[3] = m20 < 0;
        vis[4] = m21 > 0; vis[5] = m21 < 0;
        total = 0;
        foreach (vis[f]) if (vis[f]) total++;
        w = (img_w == 0) ? 1 : img_w;
        h = (img_h == 0) ? 1 : img_h;
        unit = 64'sd1 << (46 - cfas_pkg::FRACTION_BITS);
        cscale = 64'sd1 << (cfas_pkg::FRACTION_BITS - 4);
        n = 0;
        for (int f = 0; f < 6; f++) begin
            if (vis[f] && n < 3) begin
                c0 = FACE_CORNER[f][0]; c1 = FACE_CORNER[f][1]; c2 = FACE_CORNER[f][2];
                t.face = f[cfas_pkg::FACE_W-1:0];
                t.sx  = clamp32(div_nearest(px[c1] - px[c0], w * unit));
                t.shx = clamp32(div_nearest(px[c2] - px[c0], h * unit));
                t.tx  = clamp32(div_nearest(px[c0], unit) + centre_x * cscale);
                t.shy = clamp32(div_nearest(py[c1] - py[c0], w * unit));
                t.sy  = clamp32(div_nearest(py[c2] - py[c0], h * unit));
                t.ty  = clamp32(div_nearest(py[c0], unit) + centre_y * cscale);
                n++;
                t.last = (n == total || n == 3);
                face_terms_due.push_back(t);
            end
        end
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // frame driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                predict_faces('{s_angle_x, s_angle_y, s_angle_z});
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (frames_pending.size() > 0) begin
                    angles_t a;
                    a = frames_pending.pop_front();
                    s_angle_x <= a.ax;
                    s_angle_y <= a.ay;
                    s_angle_z <= a.az;
                    s_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // face item monitor and receiver stalls
    int  ready_gap = 0;
    int  hold_count = 0;
    bit  hold_done = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (face_terms_due.size() == 0) begin
                    flag_mismatch("unexpected face item", m_face_index, -1);
                end else begin
                    face_terms_t e;
                    e = face_terms_due.pop_front();
                    if (m_face_index !== e.face) flag_mismatch("face", m_face_index, e.face);
                    if (m_scale_x !== e.sx) flag_mismatch("scale_x", m_scale_x, e.sx);
                    if (m_shear_x !== e.shx) flag_mismatch("shear_x", m_shear_x, e.shx);
                    if (m_offset_x !== e.tx) flag_mismatch("offset_x", m_offset_x, e.tx);
                    if (m_shear_y !== e.shy) flag_mismatch("shear_y", m_shear_y, e.shy);
                    if (m_scale_y !== e.sy) flag_mismatch("scale_y", m_scale_y, e.sy);
                    if (m_offset_y !== e.ty) flag_mismatch("offset_y", m_offset_y, e.ty);
                    if (m_last_face !== e.last) flag_mismatch("last", m_last_face, e.last);
                end
            end
            if (hold_phase && !hold_done) begin
                // long hold-off so the pipeline fills and stalls its input
                m_ready <= 1'b0;
                hold_count <= hold_count + 1;
                if (hold_count == HOLD_CYCLES) hold_done <= 1;
            end else if (ready_gap > 0) begin
                ready_gap <= ready_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                ready_gap <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no item accepted
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [cfas_pkg::CFG_IDX_W-1:0] idx,
                             logic [cfas_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            cfas_pkg::REG_HALF_SIZE:    half_size = data[cfas_pkg::HALF_W-1:0];
            cfas_pkg::REG_CENTER_X:     centre_x = longint'($signed(data));
            cfas_pkg::REG_CENTER_Y:     centre_y = longint'($signed(data));
            cfas_pkg::REG_IMAGE_WIDTH:  img_w = data[cfas_pkg::DIM_W-1:0];
            cfas_pkg::REG_IMAGE_HEIGHT: img_h = data[cfas_pkg::DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(int hs, int cx, int cy, int w, int h);
        write_reg(cfas_pkg::REG_HALF_SIZE, hs[cfas_pkg::CFG_DATA_W-1:0]);
        write_reg(cfas_pkg::REG_CENTER_X, cx[cfas_pkg::CFG_DATA_W-1:0]);
        write_reg(cfas_pkg::REG_CENTER_Y, cy[cfas_pkg::CFG_DATA_W-1:0]);
        write_reg(cfas_pkg::REG_IMAGE_WIDTH, w[cfas_pkg::CFG_DATA_W-1:0]);
        write_reg(cfas_pkg::REG_IMAGE_HEIGHT, h[cfas_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic queue_frame(int ax, int ay, int az);
        frames_pending.push_back('{ax[cfas_pkg::ANGLE_W-1:0], ay[cfas_pkg::ANGLE_W-1:0],
                                   az[cfas_pkg::ANGLE_W-1:0]});
    endtask

    // random angles, now and then past 359
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 6) == 0)
                queue_frame($urandom_range(0, 511), $urandom_range(0, 511),
                            $urandom_range(0, 511));
            else
                queue_frame($urandom_range(0, 359), $urandom_range(0, 359),
                            $urandom_range(0, 359));
        end
    endtask

    // waits until every queued frame is sent and every face item is back
    task automatic drain();
        while (frames_pending.size() != 0 || s_valid || face_terms_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_angle_x = '0;
        s_angle_y = '0;
        s_angle_z = '0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at reset settings
        queue_frame(0, 0, 0);
        queue_frame(359, 359, 359);
        queue_frame(90, 0, 0);
        queue_frame(0, 90, 0);
        queue_frame(0, 0, 90);
        queue_frame(180, 180, 180);
        queue_frame(270, 270, 270);
        queue_frame(45, 45, 45);
        queue_frame(89, 91, 179);
        queue_frame(181, 269, 271);
        queue_frame(360, 0, 0);
        queue_frame(0, 360, 450);
        queue_frame(511, 511, 511);
        queue_frame(256, 128, 64);
        queue_frame(30, 60, 120);
        queue_frame(0, 270, 0);
        queue_frame(135, 225, 315);
        drain();

        // largest cube, extreme centres, 1x1 image: saturation
        set_all(32767, 32767, -32768, 1, 1);
        queue_frame(45, 45, 45);
        queue_frame(0, 0, 0);
        queue_random(50);
        drain();

        // empty cube, zero dimensions
        set_all(0, -32768, 32767, 0, 0);
        queue_random(30);
        drain();

        // dimensions past 4096
        set_all($urandom_range(0, 32767), $urandom_range(0, 65535),
                $urandom_range(0, 65535), 8191, 8191);
        queue_random(60);
        drain();

        // receiver holds off while frames keep coming
        set_all(1600, 0, 0, 4096, 1);
        hold_phase = 1'b1;
        queue_random(100);
        drain();
        hold_phase = 1'b0;

        // back to back, no idling
        set_all($urandom_range(0, 32767), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(1, 4096), $urandom_range(1, 4096));
        no_idle = 1'b1;
        queue_random(100);
        drain();
        no_idle = 1'b0;

        set_all($urandom_range(0, 32767), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 8191), $urandom_range(0, 8191));
        queue_random(100);
        drain();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
